/* sv/fuzzy_term_match_scorer_top_macros.svh */
// assertion macros for the port-level checker
`ifndef FUZZY_TERM_MATCH_SCORER_TOP_MACROS_SVH
`define FUZZY_TERM_MATCH_SCORER_TOP_MACROS_SVH

// property checked on the cycle after the condition
`define FTMS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ftms checker: property failed");

// property checked in the same cycle as the condition
`define FTMS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ftms checker: property failed");

`endif

/* sv/ftms_pkg.sv */
// types, codes and constants of the fuzzy term match scorer
package ftms_pkg;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_HAY    = 2'd2;
  localparam logic [1:0] MODE_END    = 2'd3;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_PREFIX   = 3'd1;
  localparam logic [2:0] KIND_BOUNDARY = 3'd2;
  localparam logic [2:0] KIND_SUBSTR   = 3'd3;
  localparam logic [2:0] KIND_SUBSEQ   = 3'd4;
  localparam logic [2:0] KIND_EMPTY    = 3'd5;

  localparam int SCORE_PREFIX   = 1200;
  localparam int SCORE_BOUNDARY = 1000;
  localparam int SCORE_SUBSTR   = 800;
  localparam int SCORE_SUBSEQ   = 380;
  localparam int BND_CAP        = 250;
  localparam int ANY_CAP        = 300;
  localparam int POS_SHIFT      = 3;

  localparam int CNT_W   = 12;
  localparam int DIV_W   = 11;
  localparam int BCAP_W  = 8;
  localparam int ACAP_W  = 9;
  localparam int SCORE_W = 15;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [15:0] SYM_SPACE  = 16'h0020;
  localparam logic [15:0] SYM_BSLASH = 16'h005C;
  localparam logic [15:0] SYM_SLASH  = 16'h002F;
  localparam logic [15:0] SYM_DASH   = 16'h002D;
  localparam logic [15:0] SYM_UNDER  = 16'h005F;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SCAN   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] symbol;
    logic        last;
  } in_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [2:0]                match_kind;
    logic                      term_truncated;
  } out_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] symbol;
    logic        emit;
  } op_item_t;

  typedef struct packed {
    logic              term_empty;
    logic              hay_empty;
    logic              prefix;
    logic              bnd_found;
    logic [BCAP_W-1:0] bnd_cap;
    logic              any_found;
    logic [ACAP_W-1:0] any_cap;
    logic              seq_done;
    logic [CNT_W-1:0]  gap;
    logic [CNT_W-1:0]  span;
    logic [DIV_W-1:0]  pos_div8;
    logic              truncated;
  } snap_t;

  function automatic logic is_sep(input logic [15:0] c);
    return (c == SYM_SPACE) || (c == SYM_BSLASH) || (c == SYM_SLASH) ||
           (c == SYM_DASH) || (c == SYM_UNDER);
  endfunction

endpackage

/* sv/fuzzy_term_match_scorer_top.sv */
// top level of the fuzzy term match scorer
//
// in_* carries one command per transfer: mode 0 appends a term character,
// mode 1 clears the term, mode 2 streams a haystack character (last set on
// the final one asks for a score), mode 3 scores the haystack seen so far.
// out_* carries one result per score request: score, match kind and the
// term truncation flag. Term edits and plain haystack characters give no result.
// Throughput is one command per cycle while in_stall is low: the execute stage
// updates the shift-and vectors and the subsequence pointer for one character
// each cycle in which it pops the queue. A score request passes through the
// queue, the snapshot register and the output register before its result shows
// on out_valid. When out_stall is high the result holds in the output register,
// one more result waits in the snapshot stage, the two-entry queue fills behind
// the next score request at its head, and in_stall rises until the output drains.
// Reset (rst_n low, synchronous) empties the queue and the pipeline, clears
// the term length, the truncation flag and the scan state; the term
// characters themselves are not cleared.
module fuzzy_term_match_scorer_top import ftms_pkg::*; #(
  parameter int TERM_MAX     = 32,
  parameter int HAYSTACK_MAX = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic     q_full;
  logic     q_push;
  op_item_t q_item;
  logic     q_pop;
  logic     q_head_valid;
  op_item_t q_head;
  logic     snap_ready;
  logic     snap_load;
  snap_t    snap;

  ftms_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  ftms_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ftms_exec #(
    .TERM_MAX     (TERM_MAX),
    .HAYSTACK_MAX (HAYSTACK_MAX)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .snap_ready (snap_ready),
    .snap_load  (snap_load),
    .snap       (snap)
  );

  ftms_score u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_load  (snap_load),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

/* sv/ftms_front.sv */
// front end: accepts input transfers and classifies them into queue entries
module ftms_front import ftms_pkg::*; (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_t      in_data,
  input  logic     q_full,
  output logic     q_push,
  output op_item_t q_item
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.symbol = in_data.symbol;
    unique case (in_data.mode)
      MODE_APPEND: begin
        q_item.op   = OP_APPEND;
        q_item.emit = 1'b0;
      end
      MODE_CLEAR: begin
        q_item.op   = OP_CLEAR;
        q_item.emit = 1'b0;
      end
      MODE_HAY: begin
        q_item.op   = OP_SCAN;
        q_item.emit = in_data.last;
      end
      default: begin
        q_item.op   = OP_END;
        q_item.emit = 1'b1;
      end
    endcase
  end

endmodule

/* sv/ftms_fifo.sv */
// two-entry queue between front end and execute stage
module ftms_fifo import ftms_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  op_item_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output op_item_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  op_item_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W_Q'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CNT_W_Q'(push) - CNT_W_Q'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* sv/ftms_exec.sv */
// execute stage: term store, shift-and match vectors and greedy subsequence pointer
module ftms_exec import ftms_pkg::*; #(
  parameter int TERM_MAX     = 32,
  parameter int HAYSTACK_MAX = 4096
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  op_item_t head,
  output logic     pop,
  input  logic     snap_ready,
  output logic     snap_load,
  output snap_t    snap
);

  localparam int LW = $clog2(TERM_MAX + 1);
  localparam int IW = $clog2(TERM_MAX);
  localparam int PW = $clog2(HAYSTACK_MAX + 1);

  logic [15:0]          term_r [TERM_MAX];
  logic [LW-1:0]        len_r, len_nxt;
  logic                 trunc_r, trunc_nxt;
  logic [TERM_MAX-1:0]  pmv_r, pmv_nxt;
  logic [TERM_MAX-1:0]  bsv_r, bsv_nxt;
  logic [15:0]          prev_r, prev_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic                 prefix_r, prefix_nxt;
  logic                 bnd_found_r, bnd_found_nxt;
  logic [BCAP_W-1:0]    bnd_cap_r, bnd_cap_nxt;
  logic                 any_found_r, any_found_nxt;
  logic [ACAP_W-1:0]    any_cap_r, any_cap_nxt;
  logic [LW-1:0]        sidx_r, sidx_nxt;
  logic                 sstart_r, sstart_nxt;
  logic [CNT_W-1:0]     gap_r, gap_nxt;
  logic [CNT_W-1:0]     span_r, span_nxt;

  logic [TERM_MAX-1:0]  eq;
  logic                 bnd;
  logic [TERM_MAX-1:0]  pmv_s, bsv_s;
  logic [LW-1:0]        len_m1;
  logic                 full_hit, bnd_hit;
  logic [PW-1:0]        start;
  logic [BCAP_W-1:0]    start_bcap;
  logic [ACAP_W-1:0]    start_acap;
  logic                 scan_en;
  logic                 seq_hit;
  logic [CNT_W-1:0]     gap_inc, span_inc;

  logic [TERM_MAX-1:0]  u_pmv, u_bsv;
  logic [15:0]          u_prev;
  logic [PW-1:0]        u_pos;
  logic                 u_prefix, u_bnd_found, u_any_found, u_sstart;
  logic [BCAP_W-1:0]    u_bnd_cap;
  logic [ACAP_W-1:0]    u_any_cap;
  logic [LW-1:0]        u_sidx;
  logic [CNT_W-1:0]     u_gap, u_span;
  logic                 scan_clr;
  logic                 term_wr;

  assign pop       = head_valid && (!head.emit || snap_ready);
  assign snap_load = pop && head.emit;

  always_comb begin
    eq = '0;
    for (int i = 0; i < TERM_MAX; i++) begin
      eq[i] = (term_r[i] == head.symbol) && (LW'(i) < len_r);
    end
  end

  assign bnd      = (pos_r == '0) || is_sep(prev_r);
  assign pmv_s    = {pmv_r[TERM_MAX-2:0], 1'b1} & eq;
  assign bsv_s    = {bsv_r[TERM_MAX-2:0], bnd} & eq;
  assign len_m1   = len_r - 1'b1;
  assign full_hit = (len_r != '0) && pmv_s[len_m1[IW-1:0]];
  assign bnd_hit  = full_hit && bsv_s[len_m1[IW-1:0]];
  assign start    = pos_r - PW'(len_m1);
  assign start_bcap = (start < BND_CAP) ? BCAP_W'(start) : BCAP_W'(BND_CAP);
  assign start_acap = (start < ANY_CAP) ? ACAP_W'(start) : ACAP_W'(ANY_CAP);
  assign scan_en  = (head.op == OP_SCAN) && (pos_r < HAYSTACK_MAX);
  assign seq_hit  = eq[sidx_r[IW-1:0]];
  assign gap_inc  = (gap_r == COUNT_MAX) ? gap_r : gap_r + 1'b1;
  assign span_inc = (span_r == COUNT_MAX) ? span_r : span_r + 1'b1;

  always_comb begin
    u_pmv       = pmv_r;
    u_bsv       = bsv_r;
    u_prev      = prev_r;
    u_pos       = pos_r;
    u_prefix    = prefix_r;
    u_bnd_found = bnd_found_r;
    u_bnd_cap   = bnd_cap_r;
    u_any_found = any_found_r;
    u_any_cap   = any_cap_r;
    u_sidx      = sidx_r;
    u_sstart    = sstart_r;
    u_gap       = gap_r;
    u_span      = span_r;
    if (scan_en) begin
      u_pmv  = pmv_s;
      u_bsv  = bsv_s;
      u_prev = head.symbol;
      u_pos  = pos_r + 1'b1;
      if (full_hit) begin
        if (!any_found_r) begin
          u_any_found = 1'b1;
          u_any_cap   = start_acap;
        end
        if (start == '0) begin
          u_prefix = 1'b1;
        end
        if (bnd_hit && !bnd_found_r) begin
          u_bnd_found = 1'b1;
          u_bnd_cap   = start_bcap;
        end
      end
      if (sidx_r < len_r) begin
        if (seq_hit) begin
          if (sstart_r) begin
            u_span = span_inc;
          end else begin
            u_sstart = 1'b1;
          end
          u_sidx = sidx_r + 1'b1;
        end else if (sstart_r) begin
          u_gap  = gap_inc;
          u_span = span_inc;
        end
      end
    end
  end

  always_comb begin
    snap.term_empty = (len_r == '0);
    snap.hay_empty  = (u_pos == '0);
    snap.prefix     = u_prefix;
    snap.bnd_found  = u_bnd_found;
    snap.bnd_cap    = u_bnd_cap;
    snap.any_found  = u_any_found;
    snap.any_cap    = u_any_cap;
    snap.seq_done   = (u_sidx == len_r);
    snap.gap        = u_gap;
    snap.span       = u_span;
    snap.pos_div8   = DIV_W'(u_pos >> POS_SHIFT);
    snap.truncated  = trunc_r;
  end

  always_comb begin
    len_nxt   = len_r;
    trunc_nxt = trunc_r;
    term_wr   = 1'b0;
    scan_clr  = 1'b0;
    if (pop) begin
      unique case (head.op)
        OP_APPEND: begin
          scan_clr = 1'b1;
          if (len_r < TERM_MAX) begin
            term_wr = 1'b1;
            len_nxt = len_r + 1'b1;
          end else begin
            trunc_nxt = 1'b1;
          end
        end
        OP_CLEAR: begin
          scan_clr  = 1'b1;
          len_nxt   = '0;
          trunc_nxt = 1'b0;
        end
        OP_SCAN: begin
          scan_clr = head.emit;
        end
        default: begin
          scan_clr = 1'b1;
        end
      endcase
    end

    if (scan_clr) begin
      pmv_nxt       = '0;
      bsv_nxt       = '0;
      prev_nxt      = '0;
      pos_nxt       = '0;
      prefix_nxt    = 1'b0;
      bnd_found_nxt = 1'b0;
      bnd_cap_nxt   = '0;
      any_found_nxt = 1'b0;
      any_cap_nxt   = '0;
      sidx_nxt      = '0;
      sstart_nxt    = 1'b0;
      gap_nxt       = '0;
      span_nxt      = '0;
    end else if (pop) begin
      pmv_nxt       = u_pmv;
      bsv_nxt       = u_bsv;
      prev_nxt      = u_prev;
      pos_nxt       = u_pos;
      prefix_nxt    = u_prefix;
      bnd_found_nxt = u_bnd_found;
      bnd_cap_nxt   = u_bnd_cap;
      any_found_nxt = u_any_found;
      any_cap_nxt   = u_any_cap;
      sidx_nxt      = u_sidx;
      sstart_nxt    = u_sstart;
      gap_nxt       = u_gap;
      span_nxt      = u_span;
    end else begin
      pmv_nxt       = pmv_r;
      bsv_nxt       = bsv_r;
      prev_nxt      = prev_r;
      pos_nxt       = pos_r;
      prefix_nxt    = prefix_r;
      bnd_found_nxt = bnd_found_r;
      bnd_cap_nxt   = bnd_cap_r;
      any_found_nxt = any_found_r;
      any_cap_nxt   = any_cap_r;
      sidx_nxt      = sidx_r;
      sstart_nxt    = sstart_r;
      gap_nxt       = gap_r;
      span_nxt      = span_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      trunc_r     <= 1'b0;
      pmv_r       <= '0;
      bsv_r       <= '0;
      prev_r      <= '0;
      pos_r       <= '0;
      prefix_r    <= 1'b0;
      bnd_found_r <= 1'b0;
      bnd_cap_r   <= '0;
      any_found_r <= 1'b0;
      any_cap_r   <= '0;
      sidx_r      <= '0;
      sstart_r    <= 1'b0;
      gap_r       <= '0;
      span_r      <= '0;
    end else begin
      len_r       <= len_nxt;
      trunc_r     <= trunc_nxt;
      pmv_r       <= pmv_nxt;
      bsv_r       <= bsv_nxt;
      prev_r      <= prev_nxt;
      pos_r       <= pos_nxt;
      prefix_r    <= prefix_nxt;
      bnd_found_r <= bnd_found_nxt;
      bnd_cap_r   <= bnd_cap_nxt;
      any_found_r <= any_found_nxt;
      any_cap_r   <= any_cap_nxt;
      sidx_r      <= sidx_nxt;
      sstart_r    <= sstart_nxt;
      gap_r       <= gap_nxt;
      span_r      <= span_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (term_wr) begin
      term_r[len_r[IW-1:0]] <= head.symbol;
    end
  end

endmodule

/* sv/ftms_score.sv */
// back end: holds the scan snapshot, picks the tier and registers the result
module ftms_score import ftms_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  snap_load,
  input  snap_t snap,
  output logic  snap_ready,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  logic  snap_v_r, snap_v_nxt;
  snap_t snap_r;
  logic  out_v_r, out_v_nxt;
  out_t  out_r;
  out_t  res;
  logic  move;

  assign move       = snap_v_r && (!out_v_r || !out_stall);
  assign snap_ready = !snap_v_r || move;
  assign snap_v_nxt = snap_load || (snap_v_r && !move);
  assign out_v_nxt  = move || (out_v_r && out_stall);
  assign out_valid  = out_v_r;
  assign out_data   = out_r;

  always_comb begin
    res.term_truncated = snap_r.truncated;
    priority if (snap_r.term_empty) begin
      res.score      = '0;
      res.match_kind = KIND_EMPTY;
    end else if (snap_r.hay_empty) begin
      res.score      = '1;
      res.match_kind = KIND_NONE;
    end else if (snap_r.prefix) begin
      res.score      = SCORE_W'(SCORE_PREFIX) - SCORE_W'(snap_r.pos_div8);
      res.match_kind = KIND_PREFIX;
    end else if (snap_r.bnd_found) begin
      res.score      = SCORE_W'(SCORE_BOUNDARY) - SCORE_W'(snap_r.bnd_cap);
      res.match_kind = KIND_BOUNDARY;
    end else if (snap_r.any_found) begin
      res.score      = SCORE_W'(SCORE_SUBSTR) - SCORE_W'(snap_r.any_cap);
      res.match_kind = KIND_SUBSTR;
    end else if (snap_r.seq_done) begin
      res.score      = SCORE_W'(SCORE_SUBSEQ) - SCORE_W'({snap_r.gap, 1'b0})
                       - SCORE_W'(snap_r.span);
      res.match_kind = KIND_SUBSEQ;
    end else begin
      res.score      = '1;
      res.match_kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap_r <= snap;
    end
    if (move) begin
      out_r <= res;
    end
  end

endmodule

/* sv/ftms_checker.sv */
// port-level checker for the fuzzy term match scorer and its bind
`include "fuzzy_term_match_scorer_top_macros.svh"

module ftms_checker import ftms_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `FTMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `FTMS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `FTMS_ASSERT_NOW(a_empty_score, out_valid && (out_data.match_kind == KIND_EMPTY), out_data.score == 15'sd0)
  `FTMS_ASSERT_NOW(a_none_score, out_valid && (out_data.match_kind == KIND_NONE), out_data.score == -15'sd1)
  `FTMS_ASSERT_NOW(a_prefix_range, out_valid && (out_data.match_kind == KIND_PREFIX), (out_data.score <= 15'sd1200) && (out_data.score >= 15'sd176))

endmodule

bind fuzzy_term_match_scorer_top ftms_checker u_ftms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
